FILE: hdl/qvr_pkg.sv
// shared widths and types for the quaternion multiplier / vector rotator
package qvr_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // a 16x17 signed product and the sum of four of them with headroom
  localparam int PROD_W = 2 * COMP_WIDTH + 1;
  localparam int ACC_W  = PROD_W + 2;

  // pipeline depth of one hamilton product unit
  localparam int HAM_LAT = 3;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [COMP_WIDTH:0]   cext_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  // second operand, one bit wider so that a conjugate stays exact
  typedef struct packed {
    cext_t w;
    cext_t x;
    cext_t y;
    cext_t z;
  } quatx_t;

  typedef struct packed {
    logic w;
    logic v;
  } sat_t;

  // data carried alongside a request through one product unit
  typedef struct packed {
    logic  cmd;
    logic  ov;
    quat_t aux;
  } side_t;

  typedef enum logic {
    CMD_PRODUCT = 1'b0,
    CMD_ROTATE  = 1'b1
  } cmd_t;

endpackage

FILE: hdl/qvr_hamilton.sv
// pipelined hamilton product with round half up and saturation
module qvr_hamilton (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  qvr_pkg::quat_t  p,
  input  qvr_pkg::quatx_t q,
  input  qvr_pkg::side_t  side_in,
  output logic           out_vld,
  output qvr_pkg::quat_t  r,
  output qvr_pkg::sat_t   sat,
  output qvr_pkg::side_t  side_out
);
  import qvr_pkg::*;

  typedef struct packed {
    comp_t val;
    logic  sat;
  } rs_t;

  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  function automatic rs_t round_sat(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] sh;
    rs_t                     res;
    rnd = acc + HALF;
    sh  = rnd >>> FRAC_BITS;
    if (sh > SAT_MAX) begin
      res.val = comp_t'(SAT_MAX);
      res.sat = 1'b1;
    end else if (sh < SAT_MIN) begin
      res.val = comp_t'(SAT_MIN);
      res.sat = 1'b1;
    end else begin
      res.val = comp_t'(sh);
      res.sat = 1'b0;
    end
    return res;
  endfunction

  comp_t pc [4];
  cext_t qc [4];

  assign pc[0] = p.w;
  assign pc[1] = p.x;
  assign pc[2] = p.y;
  assign pc[3] = p.z;
  assign qc[0] = q.w;
  assign qc[1] = q.x;
  assign qc[2] = q.y;
  assign qc[3] = q.z;

  // stage 1: all sixteen partial products
  logic                    v1_r;
  side_t                   side1_r;
  logic signed [PROD_W-1:0] prod_r [4][4];

  // stage 2: signed sums per component
  logic                    v2_r;
  side_t                   side2_r;
  logic signed [ACC_W-1:0] acc_r [4];
  logic signed [ACC_W-1:0] acc_nxt [4];

  // stage 3: rounded and saturated result
  logic  v3_r;
  side_t side3_r;
  quat_t r_r;
  sat_t  sat_r;
  rs_t   rs [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= side_in;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        // sign-extended operands, a 16x17 product in effect
        prod_r[i][j] <= PROD_W'(pc[i]) * PROD_W'(qc[j]);
      end
    end
  end

  always_comb begin
    acc_nxt[0] = ACC_W'(prod_r[0][0]) - ACC_W'(prod_r[1][1])
               - ACC_W'(prod_r[2][2]) - ACC_W'(prod_r[3][3]);
    acc_nxt[1] = ACC_W'(prod_r[0][1]) + ACC_W'(prod_r[1][0])
               + ACC_W'(prod_r[2][3]) - ACC_W'(prod_r[3][2]);
    acc_nxt[2] = ACC_W'(prod_r[0][2]) - ACC_W'(prod_r[1][3])
               + ACC_W'(prod_r[2][0]) + ACC_W'(prod_r[3][1]);
    acc_nxt[3] = ACC_W'(prod_r[0][3]) + ACC_W'(prod_r[1][2])
               - ACC_W'(prod_r[2][1]) + ACC_W'(prod_r[3][0]);
  end

  always_ff @(posedge clk) begin
    side2_r <= side1_r;
    for (int i = 0; i < 4; i++) begin
      acc_r[i] <= acc_nxt[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rs[i] = round_sat(acc_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    side3_r <= side2_r;
    r_r.w   <= rs[0].val;
    r_r.x   <= rs[1].val;
    r_r.y   <= rs[2].val;
    r_r.z   <= rs[3].val;
    sat_r.w <= rs[0].sat;
    sat_r.v <= rs[1].sat | rs[2].sat | rs[3].sat;
  end

  assign out_vld  = v3_r;
  assign r        = r_r;
  assign sat      = sat_r;
  assign side_out = side3_r;

  // valid travels one stage per cycle
  a_vld_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |=> out_vld)
    else $error("valid lost between sum and output stage");

  // a saturated scalar sits at a rail
  a_sat_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && sat.w |-> r.w == comp_t'(SAT_MAX) || r.w == comp_t'(SAT_MIN))
    else $error("scalar flagged saturated but not at a limit");

  // a saturated vector part leaves at least one component at a rail
  a_sat_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && sat.v |->
      r.x == comp_t'(SAT_MAX) || r.x == comp_t'(SAT_MIN) ||
      r.y == comp_t'(SAT_MAX) || r.y == comp_t'(SAT_MIN) ||
      r.z == comp_t'(SAT_MAX) || r.z == comp_t'(SAT_MIN))
    else $error("vector flagged saturated but no component at a limit");

endmodule

FILE: hdl/quaternion_vector_rotation.sv
// top level: quaternion hamilton product and vector rotation pipeline
//
// One request (two Q2.14 quaternions and a command) is taken on every clock
// edge at which start is high; busy is held low, since nothing in the block
// ever stalls. Each request gives exactly one result, shown for one cycle
// with out_valid high, in request order. The receiver cannot hold results
// off, and needs none: the pipeline runs at one request per cycle. It is
// made of two chained hamilton product units of three stages each
// (partial products, signed sums, round and saturate) and the output
// register. cmd 0 returns a*b from the first unit; cmd 1 feeds the
// rotation a*(0,v) through the first unit and multiplies by conj(a) in the
// second, returning x, y, z with res_w forced to zero.
module quaternion_vector_rotation (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  qvr_pkg::comp_t    in_a_w,
  input  qvr_pkg::comp_t    in_a_x,
  input  qvr_pkg::comp_t    in_a_y,
  input  qvr_pkg::comp_t    in_a_z,
  input  qvr_pkg::comp_t    in_b_w,
  input  qvr_pkg::comp_t    in_b_x,
  input  qvr_pkg::comp_t    in_b_y,
  input  qvr_pkg::comp_t    in_b_z,
  output logic              out_valid,
  output qvr_pkg::comp_t    out_res_w,
  output qvr_pkg::comp_t    out_res_x,
  output qvr_pkg::comp_t    out_res_y,
  output qvr_pkg::comp_t    out_res_z,
  output logic              out_overflow
);
  import qvr_pkg::*;

  // first pass: a * b, or a * (0, v) when rotating
  quat_t  a1;
  quatx_t b1;
  side_t  side1_in;
  logic   is_rot;

  assign is_rot = (in_cmd == CMD_ROTATE);

  assign a1.w = in_a_w;
  assign a1.x = in_a_x;
  assign a1.y = in_a_y;
  assign a1.z = in_a_z;

  // the scalar of b is dropped when rotating a vector
  assign b1.w = is_rot ? '0 : cext_t'(in_b_w);
  assign b1.x = cext_t'(in_b_x);
  assign b1.y = cext_t'(in_b_y);
  assign b1.z = cext_t'(in_b_z);

  assign side1_in.cmd = in_cmd;
  assign side1_in.ov  = 1'b0;
  assign side1_in.aux = a1;

  logic  vld1;
  quat_t t1;
  sat_t  sat1;
  side_t side1_out;

  qvr_hamilton u_ham1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .p        (a1),
    .q        (b1),
    .side_in  (side1_in),
    .out_vld  (vld1),
    .r        (t1),
    .sat      (sat1),
    .side_out (side1_out)
  );

  // second pass: t * conj(a), conjugate kept exact in 17 bits
  quatx_t conj_a;
  side_t  side2_in;

  assign conj_a.w = cext_t'(side1_out.aux.w);
  assign conj_a.x = -cext_t'(side1_out.aux.x);
  assign conj_a.y = -cext_t'(side1_out.aux.y);
  assign conj_a.z = -cext_t'(side1_out.aux.z);

  // every component of the first product counts towards overflow
  assign side2_in.cmd = side1_out.cmd;
  assign side2_in.ov  = sat1.w | sat1.v;
  assign side2_in.aux = t1;

  logic  vld2;
  quat_t r2;
  sat_t  sat2;
  side_t side2_out;

  qvr_hamilton u_ham2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld1),
    .p        (t1),
    .q        (conj_a),
    .side_in  (side2_in),
    .out_vld  (vld2),
    .r        (r2),
    .sat      (sat2),
    .side_out (side2_out)
  );

  // output register: product results ride through the second unit's side path
  logic  out_valid_r;
  logic  out_cmd_r;
  quat_t res_r;
  quat_t res_nxt;
  logic  ovf_r;
  logic  ovf_nxt;

  always_comb begin
    unique case (side2_out.cmd)
      CMD_ROTATE: begin
        // scalar of the second product is discarded and not flagged
        res_nxt.w = '0;
        res_nxt.x = r2.x;
        res_nxt.y = r2.y;
        res_nxt.z = r2.z;
        ovf_nxt   = side2_out.ov | sat2.v;
      end
      default: begin
        res_nxt = side2_out.aux;
        ovf_nxt = side2_out.ov;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    ovf_r     <= ovf_nxt;
    out_cmd_r <= side2_out.cmd;
  end

  assign busy         = 1'b0;
  assign out_valid    = out_valid_r;
  assign out_res_w    = res_r.w;
  assign out_res_x    = res_r.x;
  assign out_res_y    = res_r.y;
  assign out_res_z    = res_r.z;
  assign out_overflow = ovf_r;

  // every result stems from a request that passed both units and the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2 * HAM_LAT + 1))
    else $error("result without a matching request");

  // a request that leaves the second unit always yields a result
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    vld2 |=> out_valid)
    else $error("request lost at the output register");

  // rotated vectors carry a zero scalar
  a_rot_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_r == CMD_ROTATE |-> out_res_w == '0)
    else $error("rotation result has a non-zero scalar");

endmodule
